[design/kuf_pkg.sv]
package kuf_pkg;

    localparam int NODE_W             = 10;
    localparam int COUNT_W            = 11;
    localparam int WEIGHT_W           = 31;
    localparam int COST_W             = 42;
    localparam int CMD_W              = 2;
    localparam int MAX_NODES_DEFAULT  = 1024;
    localparam int NODE_COUNT_DEFAULT = 1024;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_JOIN  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd2;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_WALK,
        ST_COMP,
        ST_LINK,
        ST_RESULT
    } kuf_state_t;

    typedef struct packed {
        logic fire;
        logic clear;
        logic merged;
        logic is_edge;
    } kuf_tally_op_t;

endpackage

[design/kuf_parent_ram.sv]
module kuf_parent_ram #(
    parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEFAULT
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [$clog2(MAX_NODES)-1:0] waddr,
    input  logic [$clog2(MAX_NODES)-1:0] wdata,
    input  logic                         re,
    input  logic [$clog2(MAX_NODES)-1:0] raddr,
    output logic [$clog2(MAX_NODES)-1:0] rdata
);
    import kuf_pkg::*;

    localparam int IDX_W = $clog2(MAX_NODES);

    logic [IDX_W-1:0] mem [MAX_NODES];
    logic [IDX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // write-first: a read of the entry being written sees the new word
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/kuf_seq.sv]
module kuf_seq #(
    parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [kuf_pkg::CMD_W-1:0]     command,
    input  logic [kuf_pkg::NODE_W-1:0]    first_node,
    input  logic [kuf_pkg::NODE_W-1:0]    second_node,
    input  logic [kuf_pkg::WEIGHT_W-1:0]  weight,
    input  logic [kuf_pkg::COUNT_W-1:0]   active_nodes,
    input  logic                          out_free,
    output logic                          ram_we,
    output logic [$clog2(MAX_NODES)-1:0]  ram_waddr,
    output logic [$clog2(MAX_NODES)-1:0]  ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(MAX_NODES)-1:0]  ram_raddr,
    input  logic [$clog2(MAX_NODES)-1:0]  ram_rdata,
    output kuf_pkg::kuf_tally_op_t        tally_op,
    output logic [kuf_pkg::WEIGHT_W-1:0]  item_weight
);
    import kuf_pkg::*;

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int WIDE_W = IDX_W + NODE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_NODES - 1);

    kuf_state_t state_reg, state_next;

    logic [IDX_W-1:0]    sweep_reg, sweep_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [IDX_W-1:0]    start_reg, start_next;
    logic [IDX_W-1:0]    root_reg, root_next;
    logic [IDX_W-1:0]    ra_reg, ra_next;
    logic [IDX_W-1:0]    b_reg, b_next;
    logic                phase_reg, phase_next;
    logic                clear_reg, clear_next;
    logic                merged_reg, merged_next;
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [WEIGHT_W-1:0] weight_reg, weight_next;

    logic [WIDE_W-1:0] a_wide;
    logic [WIDE_W-1:0] b_wide;
    logic [IDX_W-1:0]  a_idx;
    logic [IDX_W-1:0]  b_idx;
    logic              accept;
    logic              in_range;
    logic              walk_go;
    logic              walk_hit;
    logic              comp_hit;
    logic              find_done;
    logic              comp_go;
    logic [IDX_W-1:0]  found;
    logic              sweep_last;

    assign a_wide = WIDE_W'(first_node);
    assign b_wide = WIDE_W'(second_node);
    assign a_idx  = a_wide[IDX_W-1:0];
    assign b_idx  = b_wide[IDX_W-1:0];

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_range = ({1'b0, first_node} < active_nodes)
                   && ({1'b0, second_node} < active_nodes);
    assign walk_go  = ((command == CMD_JOIN) || (command == CMD_EDGE)) && in_range;

    assign walk_hit   = (state_reg == ST_WALK) && (ram_rdata == cur_reg);
    assign comp_hit   = (state_reg == ST_COMP) && (ram_rdata == root_reg);
    assign find_done  = (walk_hit && (start_reg == cur_reg)) || comp_hit;
    assign comp_go    = walk_hit && (start_reg != cur_reg);
    assign found      = (state_reg == ST_WALK) ? cur_reg : root_reg;
    assign sweep_last = (sweep_reg == LAST_IDX);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                if (sweep_last)
                begin
                    state_next = clear_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (command == CMD_CLEAR)
                    begin
                        state_next = ST_SWEEP;
                    end
                    else if (walk_go)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_WALK:
            begin
                if (find_done && phase_reg)
                begin
                    state_next = ST_LINK;
                end
                else if (comp_go)
                begin
                    state_next = ST_COMP;
                end
            end
            ST_COMP:
            begin
                if (find_done)
                begin
                    state_next = phase_reg ? ST_LINK : ST_WALK;
                end
            end
            ST_LINK:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = cur_reg;
        ram_wdata        = root_reg;
        ram_re           = 1'b0;
        ram_raddr        = cur_reg;
        tally_op.fire    = 1'b0;
        tally_op.clear   = clear_reg;
        tally_op.merged  = merged_reg;
        tally_op.is_edge = (cmd_reg == CMD_EDGE);
        unique case (state_reg)
            ST_SWEEP:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                ram_wdata = sweep_reg;
            end
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ram_re    = accept && walk_go;
                ram_raddr = a_idx;
            end
            ST_WALK:
            begin
                ram_re = 1'b1;
                if (find_done)
                begin
                    ram_raddr = b_reg;
                end
                else if (walk_hit)
                begin
                    ram_raddr = start_reg;
                end
                else
                begin
                    ram_raddr = ram_rdata;
                end
            end
            ST_COMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = cur_reg;
                ram_wdata = root_reg;
                ram_re    = 1'b1;
                ram_raddr = find_done ? b_reg : ram_rdata;
            end
            ST_LINK:
            begin
                ram_we    = (ra_reg != root_reg);
                ram_waddr = ra_reg;
                ram_wdata = root_reg;
            end
            ST_RESULT:
            begin
                tally_op.fire = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        sweep_next  = sweep_reg;
        cur_next    = cur_reg;
        start_next  = start_reg;
        root_next   = root_reg;
        ra_next     = ra_reg;
        b_next      = b_reg;
        phase_next  = phase_reg;
        clear_next  = clear_reg;
        merged_next = merged_reg;
        cmd_next    = cmd_reg;
        weight_next = weight_reg;
        unique case (state_reg)
            ST_SWEEP:
            begin
                sweep_next = sweep_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = command;
                    weight_next = weight;
                    clear_next  = (command == CMD_CLEAR);
                    merged_next = 1'b0;
                    sweep_next  = '0;
                    phase_next  = 1'b0;
                    cur_next    = a_idx;
                    start_next  = a_idx;
                    b_next      = b_idx;
                end
            end
            ST_WALK, ST_COMP:
            begin
                if (find_done)
                begin
                    root_next = found;
                    if (!phase_reg)
                    begin
                        ra_next    = found;
                        phase_next = 1'b1;
                        cur_next   = b_reg;
                        start_next = b_reg;
                    end
                end
                else if (comp_go)
                begin
                    root_next = cur_reg;
                    cur_next  = start_reg;
                end
                else
                begin
                    cur_next = ram_rdata;
                end
            end
            ST_LINK:
            begin
                merged_next = (ra_reg != root_reg);
            end
            default:
            begin
                merged_next = merged_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
            sweep_reg <= '0;
            clear_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            clear_reg <= clear_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        start_reg  <= start_next;
        root_reg   <= root_next;
        ra_reg     <= ra_next;
        b_reg      <= b_next;
        merged_reg <= merged_next;
        cmd_reg    <= cmd_next;
        weight_reg <= weight_next;
    end

    assign item_weight = weight_reg;

endmodule

[design/kuf_tally.sv]
module kuf_tally #(
    parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kuf_pkg::kuf_tally_op_t        tally_op,
    input  logic [kuf_pkg::WEIGHT_W-1:0]  item_weight,
    input  logic [kuf_pkg::COUNT_W-1:0]   active_nodes,
    output logic                          out_free,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          merged,
    output logic [kuf_pkg::COST_W-1:0]    total_cost,
    output logic [kuf_pkg::COUNT_W-1:0]   components,
    output logic                          connected
);
    import kuf_pkg::*;

    localparam int RESET_COMP = (MAX_NODES < NODE_COUNT_DEFAULT) ? MAX_NODES
                                                                 : NODE_COUNT_DEFAULT;

    logic [COUNT_W-1:0] comp_reg, comp_next;
    logic [COST_W-1:0]  cost_reg, cost_next;
    logic               out_valid_reg, out_valid_next;
    logic               merged_reg;
    logic [COST_W-1:0]  total_cost_reg;
    logic [COUNT_W-1:0] components_reg;
    logic               connected_reg;
    logic [COST_W:0]    cost_sum;

    assign out_free = !out_valid_reg || out_ready;
    assign cost_sum = {1'b0, cost_reg} + (COST_W + 1)'(item_weight);

    always_comb
    begin
        comp_next      = comp_reg;
        cost_next      = cost_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (tally_op.fire)
        begin
            out_valid_next = 1'b1;
            if (tally_op.clear)
            begin
                comp_next = active_nodes;
                cost_next = '0;
            end
            else if (tally_op.merged)
            begin
                if (comp_reg > COUNT_W'(1))
                begin
                    comp_next = comp_reg - 1'b1;
                end
                if (tally_op.is_edge)
                begin
                    cost_next = cost_sum[COST_W] ? COST_MAX : cost_sum[COST_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_reg      <= COUNT_W'(RESET_COMP);
            cost_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            comp_reg      <= comp_next;
            cost_reg      <= cost_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tally_op.fire)
        begin
            merged_reg     <= tally_op.merged && !tally_op.clear;
            total_cost_reg <= cost_next;
            components_reg <= comp_next;
            connected_reg  <= (comp_next == COUNT_W'(1));
        end
    end

    assign out_valid  = out_valid_reg;
    assign merged     = merged_reg;
    assign total_cost = total_cost_reg;
    assign components = components_reg;
    assign connected  = connected_reg;

endmodule

[design/kruskal_union_find_accumulator.sv]
// A join or edge word walks each node's path to its root, compressing it, then links
//   the roots; unused or out-of-range words report at once, a clear sweeps the table.
// One word in flight; the next is accepted only once the result word is registered.
// Reset: asynchronous, active low; afterwards the whole parent table is swept with
//   in_ready low, node_count is 1024 and the cost is zero.
module kruskal_union_find_accumulator #(
    parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kuf_pkg::COUNT_W-1:0]   node_count,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [kuf_pkg::CMD_W-1:0]     command,
    input  logic [kuf_pkg::NODE_W-1:0]    first_node,
    input  logic [kuf_pkg::NODE_W-1:0]    second_node,
    input  logic [kuf_pkg::WEIGHT_W-1:0]  weight,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          merged,
    output logic [kuf_pkg::COST_W-1:0]    total_cost,
    output logic [kuf_pkg::COUNT_W-1:0]   components,
    output logic                          connected
);
    import kuf_pkg::*;

    localparam int IDX_W   = $clog2(MAX_NODES);
    localparam int MAXN_W  = $clog2(MAX_NODES + 1);
    localparam int CMP_W   = (MAXN_W > COUNT_W) ? MAXN_W : COUNT_W;

    logic [COUNT_W-1:0] node_count_reg, node_count_next;
    logic [CMP_W-1:0]   nc_wide;
    logic [CMP_W-1:0]   active_wide;
    logic [COUNT_W-1:0] active_nodes;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [IDX_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [IDX_W-1:0]    ram_raddr;
    logic [IDX_W-1:0]    ram_rdata;
    kuf_tally_op_t       tally_op;
    logic [WEIGHT_W-1:0] item_weight;
    logic                out_free;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        node_count_next = node_count_reg;
        if (cfg_valid)
        begin
            node_count_next = node_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= COUNT_W'(NODE_COUNT_DEFAULT);
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    // clamp the node count to 1 .. MAX_NODES
    assign nc_wide = CMP_W'(node_count_reg);

    always_comb
    begin
        priority if (nc_wide == '0)
        begin
            active_wide = CMP_W'(1);
        end
        else if (nc_wide > CMP_W'(MAX_NODES))
        begin
            active_wide = CMP_W'(MAX_NODES);
        end
        else
        begin
            active_wide = nc_wide;
        end
    end

    assign active_nodes = active_wide[COUNT_W-1:0];

    kuf_parent_ram #(
        .MAX_NODES (MAX_NODES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kuf_seq #(
        .MAX_NODES (MAX_NODES)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .first_node   (first_node),
        .second_node  (second_node),
        .weight       (weight),
        .active_nodes (active_nodes),
        .out_free     (out_free),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .tally_op     (tally_op),
        .item_weight  (item_weight)
    );

    kuf_tally #(
        .MAX_NODES (MAX_NODES)
    ) u_tally (
        .clk          (clk),
        .rst_n        (rst_n),
        .tally_op     (tally_op),
        .item_weight  (item_weight),
        .active_nodes (active_nodes),
        .out_free     (out_free),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .merged       (merged),
        .total_cost   (total_cost),
        .components   (components),
        .connected    (connected)
    );

endmodule

[design/kuf_checker.sv]
module kuf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          merged,
    input logic [kuf_pkg::COST_W-1:0]    total_cost,
    input logic [kuf_pkg::COUNT_W-1:0]   components,
    input logic                          connected
);
    import kuf_pkg::*;

    // one word in flight: after an accept the input side closes
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a word is in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (connected == (components == COUNT_W'(1))))
    else $error("connected flag disagrees with component count");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (components != '0))
    else $error("component count reached zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(merged)
            && $stable(total_cost) && $stable(components)))
    else $error("stalled result word changed");

endmodule

bind kruskal_union_find_accumulator kuf_checker u_kuf_checker (.*);

[sim/tb_kruskal_union_find_accumulator.sv]
`timescale 1ns / 100ps

module tb_kruskal_union_find_accumulator;
    import kuf_pkg::*;

    localparam int NODES       = MAX_NODES_DEFAULT;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 40;
    localparam int CYCLE_LIMIT = 3_000_000;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic               merged;
        logic [COST_W-1:0]  total_cost;
        logic [COUNT_W-1:0] components;
        logic               connected;
    } mst_report_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [COUNT_W-1:0]  node_count  = '0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [CMD_W-1:0]    command     = CMD_CLEAR;
    logic [NODE_W-1:0]   first_node  = '0;
    logic [NODE_W-1:0]   second_node = '0;
    logic [WEIGHT_W-1:0] weight      = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic                merged;
    logic [COST_W-1:0]   total_cost;
    logic [COUNT_W-1:0]  components;
    logic                connected;

    logic [NODE_W-1:0]  forest_parent [0:NODES-1];
    logic [COUNT_W-1:0] set_count;
    logic [COST_W-1:0]  mst_cost;
    logic [COUNT_W-1:0] node_limit;

    mst_report_t expected_reports [$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    bit          calm           = 1'b0;
    bit          sink_hold      = 1'b0;

    kruskal_union_find_accumulator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .node_count  (node_count),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .first_node  (first_node),
        .second_node (second_node),
        .weight      (weight),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .merged      (merged),
        .total_cost  (total_cost),
        .components  (components),
        .connected   (connected)
    );

    always #5 clk = ~clk;

    function automatic logic [COUNT_W-1:0] live_nodes();
        if (node_limit == 0)
            return COUNT_W'(1);
        if (node_limit > NODES)
            return COUNT_W'(NODES);
        return node_limit;
    endfunction

    function automatic logic [NODE_W-1:0] root_of(input logic [NODE_W-1:0] node);
        logic [NODE_W-1:0] root;
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] nxt;
        int steps;
        root  = node;
        steps = 0;
        while (forest_parent[root] != root && steps < NODES) begin
            root = forest_parent[root];
            steps++;
        end
        // compress: point every node on the chain at the root
        cur   = node;
        steps = 0;
        while (cur != root && steps < NODES) begin
            nxt = forest_parent[cur];
            forest_parent[cur] = root;
            cur = nxt;
            steps++;
        end
        return root;
    endfunction

    function automatic mst_report_t forest_apply(input logic [CMD_W-1:0] cmd,
                                                 input logic [NODE_W-1:0] a,
                                                 input logic [NODE_W-1:0] b,
                                                 input logic [WEIGHT_W-1:0] w);
        mst_report_t        rep;
        logic [COUNT_W-1:0] span;
        logic [NODE_W-1:0]  ra;
        logic [NODE_W-1:0]  rb;
        logic [COST_W:0]    sum;
        int i;
        rep.merged = 1'b0;
        span = live_nodes();
        if (cmd == CMD_CLEAR) begin
            for (i = 0; i < NODES; i++)
                forest_parent[i] = NODE_W'(i);
            set_count = span;
            mst_cost  = '0;
        end else if ((cmd == CMD_JOIN || cmd == CMD_EDGE) &&
                     {1'b0, a} < span && {1'b0, b} < span) begin
            ra = root_of(a);
            rb = root_of(b);
            if (ra != rb) begin
                forest_parent[ra] = rb;
                if (set_count > 1)
                    set_count = set_count - 1'b1;
                rep.merged = 1'b1;
                if (cmd == CMD_EDGE) begin
                    sum = {1'b0, mst_cost} + (COST_W + 1)'(w);
                    mst_cost = sum[COST_W] ? COST_MAX : sum[COST_W-1:0];
                end
            end
        end
        rep.total_cost = mst_cost;
        rep.components = set_count;
        rep.connected  = (set_count == 1);
        return rep;
    endfunction

    function automatic void check_field(input string label, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [NODE_W-1:0] a,
                             input logic [NODE_W-1:0] b, input logic [WEIGHT_W-1:0] w);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        first_node  <= a;
        second_node <= b;
        weight      <= w;
        do @(posedge clk); while (!in_ready);
        expected_reports.insert(expected_reports.size(), forest_apply(cmd, a, b, w));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (expected_reports.size() != 0);
    endtask

    task automatic write_node_count(input logic [COUNT_W-1:0] value);
        drain_results();
        cfg_valid  <= 1'b1;
        node_count <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid  <= 1'b0;
        node_limit = value;
    endtask

    task automatic test_reset_defaults();
        send_word(CMD_EDGE, 10'd0, 10'd1023, 31'h7FFF_FFFF);
        send_word(CMD_EDGE, 10'd1023, 10'd0, 31'd5);
        send_word(CMD_JOIN, 10'd512, 10'd511, 31'h5555_5555);
        send_word(CMD_EDGE, 10'd7, 10'd7, 31'd1);
        send_word(CMD_UNUSED, 10'd1023, 10'd1023, 31'h7FFF_FFFF);
        send_word(CMD_CLEAR, 10'd1023, 10'd1023, 31'h7FFF_FFFF);
    endtask

    task automatic test_node_count_extremes();
        write_node_count(11'd0);
        send_word(CMD_CLEAR, 10'd0, 10'd0, 31'd0);
        send_word(CMD_EDGE, 10'd0, 10'd0, 31'd9);
        send_word(CMD_EDGE, 10'd1, 10'd0, 31'd9);
        write_node_count(11'd2047);
        send_word(CMD_CLEAR, 10'd0, 10'd0, 31'd0);
        send_word(CMD_EDGE, 10'd1023, 10'd512, 31'd0);
        write_node_count(11'd1);
        send_word(CMD_EDGE, 10'd1, 10'd2, 31'd3);
        send_word(CMD_CLEAR, 10'd0, 10'd0, 31'd0);
    endtask

    task automatic test_count_floor();
        write_node_count(11'd2);
        send_word(CMD_CLEAR, 10'd0, 10'd0, 31'd0);
        write_node_count(11'd1024);
        send_word(CMD_EDGE, 10'd0, 10'd1, 31'd100);
        send_word(CMD_EDGE, 10'd2, 10'd3, 31'd200);
        send_word(CMD_JOIN, 10'd900, 10'd1023, 31'd7);
        send_word(CMD_EDGE, 10'd0, 10'd3, 31'd50);
        write_node_count(11'd4);
        send_word(CMD_EDGE, 10'd10, 10'd11, 31'd60);
        send_word(CMD_EDGE, 10'd0, 10'd900, 31'd70);
        send_word(CMD_CLEAR, 10'd0, 10'd0, 31'd0);
    endtask

    task automatic test_backpressure();
        int k;
        write_node_count(11'd24);
        send_word(CMD_CLEAR, 10'd0, 10'd0, 31'd0);
        sink_hold = 1'b1;
        for (k = 0; k < 40; k++)
            send_word(CMD_EDGE, NODE_W'($urandom_range(0, 23)), NODE_W'($urandom_range(0, 23)),
                      WEIGHT_W'(k * 1000));
        drain_results();
        for (k = 0; k < 20; k++)
            send_word(CMD_JOIN, NODE_W'($urandom_range(0, 23)), NODE_W'($urandom_range(0, 23)),
                      WEIGHT_W'($urandom));
    endtask

    task automatic test_random_forests(input int budget);
        int sent;
        int span;
        int reach;
        int phase_len;
        int pick;
        int k;
        logic [WEIGHT_W-1:0] w;
        logic [NODE_W-1:0]   a;
        logic [NODE_W-1:0]   b;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                span = NODES;
            else if (pick == 1)
                span = $urandom_range(0, 2047);
            else if (pick == 2)
                span = $urandom_range(513, NODES);
            else
                span = $urandom_range(2, 48);
            reach = (span == 0) ? 1 : (span > NODES) ? NODES : span;
            write_node_count(COUNT_W'(span));
            calm = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 4) != 0) begin
                send_word(CMD_CLEAR, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));
                sent++;
            end
            phase_len = (reach > 64) ? $urandom_range(60, 150)
                                     : $urandom_range(reach + 4, reach * 3 + 8);
            w = WEIGHT_W'($urandom_range(0, 1000));
            for (k = 0; k < phase_len && sent < budget; k++) begin
                a = NODE_W'($urandom_range(0, reach - 1));
                b = NODE_W'($urandom_range(0, reach - 1));
                w = w + WEIGHT_W'($urandom_range(0, 1 << 20));
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    send_word(CMD_EDGE, a, b, w);
                else if (pick < 80)
                    send_word(CMD_JOIN, a, b, WEIGHT_W'($urandom));
                else if (pick < 87)
                    send_word(pick[0] ? CMD_EDGE : CMD_JOIN, NODE_W'($urandom),
                              NODE_W'($urandom), WEIGHT_W'($urandom));
                else if (pick < 92)
                    send_word(CMD_UNUSED, NODE_W'($urandom), NODE_W'($urandom),
                              WEIGHT_W'($urandom));
                else if (pick < 94)
                    send_word(CMD_CLEAR, NODE_W'($urandom), NODE_W'($urandom),
                              WEIGHT_W'($urandom));
                else
                    send_word(CMD_EDGE, a, b, WEIGHT_W'($urandom));
                sent++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin : result_sink
        int stall;
        mst_report_t want;
        stall = 0;
        forever begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: result with none expected: merged %0d cost %0d components %0d",
                             $time, merged, total_cost, components);
                    mismatch_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("merged", 64'(want.merged), 64'(merged));
                    check_field("total_cost", 64'(want.total_cost), 64'(total_cost));
                    check_field("components", 64'(want.components), 64'(components));
                    check_field("connected", 64'(want.connected), 64'(connected));
                end
                stall = calm ? 0 : $urandom_range(0, 13);
            end
            if (sink_hold) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                sink_hold = 1'b0;
            end
            out_ready <= (stall == 0);
            if (stall > 0)
                stall--;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : main
        node_limit = COUNT_W'(NODE_COUNT_DEFAULT);
        void'(forest_apply(CMD_CLEAR, '0, '0, '0));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_node_count_extremes();
        test_count_floor();
        test_backpressure();
        test_random_forests(870);
        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
